>>> src/ssbfs_pkg.sv
`timescale 1ns / 1ps
// shared types, register and status codes, candidate tables for the
// sync block first-symbol lookup; no dependencies
package ssbfs_pkg;

  // field widths
  localparam int PatW     = 3;
  localparam int CarrierW = 27;
  localparam int MaskW    = 64;
  localparam int IndexW   = 6;
  localparam int SymW     = 10;
  localparam int StatusW  = 2;

  // scan limit on candidate positions (8 to 64)
  localparam int MaxPositions = 64;
  localparam int LenW         = 7;

  // set-bit search is split into byte groups
  localparam int GroupW  = 8;
  localparam int NGroups = MaskW / GroupW;
  localparam int GrpIdxW = $clog2(NGroups);
  localparam int BitIdxW = $clog2(GroupW);
  localparam int CntW    = $clog2(GroupW + 1);
  localparam int PreW    = $clog2(MaskW + 1);

  // configuration bus
  localparam int DataW = 64;
  localparam int AddrW = 5;

  // register indexes, paddr[4:3]
  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_CARRIER = 2'd1;
  localparam logic [1:0] REG_DUPLEX  = 2'd2;
  localparam logic [1:0] REG_MASK    = 2'd3;

  // block patterns
  localparam logic [PatW-1:0] PAT_A = 3'd0;
  localparam logic [PatW-1:0] PAT_B = 3'd1;
  localparam logic [PatW-1:0] PAT_C = 3'd2;
  localparam logic [PatW-1:0] PAT_D = 3'd3;
  localparam logic [PatW-1:0] PAT_E = 3'd4;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_FOUND       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_PATTERN = 2'd1;
  localparam logic [StatusW-1:0] STATUS_MISSING     = 2'd2;

  // frequency thresholds in kHz
  localparam logic [CarrierW-1:0] Thr3GhzKhz = 27'd3000000;
  localparam logic [CarrierW-1:0] Thr2g3Khz  = 27'd2300000;

  // candidate tables
  localparam logic [SymW-1:0] BaseTwo [2] = '{10'd2, 10'd8};
  localparam logic [SymW-1:0] BaseFour [4] = '{10'd4, 10'd8, 10'd16, 10'd20};
  localparam logic [SymW-1:0] BaseEight [8] =
    '{10'd8, 10'd12, 10'd16, 10'd20, 10'd32, 10'd36, 10'd40, 10'd44};
  localparam logic [SymW-1:0] StepsD [16] =
    '{10'd0, 10'd1, 10'd2, 10'd3, 10'd5, 10'd6, 10'd7, 10'd8,
      10'd10, 10'd11, 10'd12, 10'd13, 10'd15, 10'd16, 10'd17, 10'd18};
  localparam logic [SymW-1:0] StepsE [8] =
    '{10'd0, 10'd1, 10'd2, 10'd3, 10'd5, 10'd6, 10'd7, 10'd8};

  // configuration as seen by the pipeline
  typedef struct packed {
    logic [PatW-1:0]     pattern;
    logic [CarrierW-1:0] carrier_khz;
    logic                duplex_tdd;
    logic [MaskW-1:0]    active_mask;
  } cfg_t;

  // number of scanned candidate positions, clipped to the scan limit
  function automatic logic [LenW-1:0] list_len(logic [PatW-1:0] pat,
                                               logic [CarrierW-1:0] khz,
                                               logic tdd);
    logic           above3;
    logic           low_c;
    logic [LenW-1:0] len;
    above3 = khz > Thr3GhzKhz;
    low_c  = tdd ? (khz <= Thr2g3Khz) : !above3;
    case (pat)
      PAT_A, PAT_B: len = above3 ? 7'd8 : 7'd4;
      PAT_C:        len = low_c ? 7'd4 : 7'd8;
      PAT_D, PAT_E: len = 7'd64;
      default:      len = 7'd0;
    endcase
    if (len > LenW'(MaxPositions)) len = LenW'(MaxPositions);
    return len;
  endfunction

  // first symbol of a candidate position
  function automatic logic [SymW-1:0] cand_symbol(logic [PatW-1:0] pat,
                                                  logic [IndexW-1:0] pos);
    logic [SymW-1:0] sym;
    case (pat)
      PAT_A, PAT_C: sym = BaseTwo[pos[0]] + SymW'(pos[5:1]) * 10'd14;
      PAT_B:        sym = BaseFour[pos[1:0]] + SymW'(pos[5:2]) * 10'd28;
      PAT_D:        sym = BaseFour[pos[1:0]] + StepsD[pos[5:2]] * 10'd28;
      PAT_E:        sym = BaseEight[pos[2:0]] + StepsE[pos[5:3]] * 10'd56;
      default:      sym = '0;
    endcase
    return sym;
  endfunction

endpackage

>>> src/ssb_burst_first_symbol_top.sv
`timescale 1ns / 1ps
// sync block first symbol lookup, top level: an accepted item shows its
// result on out_valid after the four pipeline stages, one item per cycle
// sustained while out_stall is low; the rate is set by the pipelined stages in ssbfs_pipe
// synchronous reset clears all stage valids and the configuration registers to 0
// holds the configuration registers and apb port; depends on ssbfs_pkg
module ssb_burst_first_symbol_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssbfs_pkg::AddrW-1:0]      paddr,
  input  logic [ssbfs_pkg::DataW-1:0]      pwdata,
  output logic [ssbfs_pkg::DataW-1:0]      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ssbfs_pkg::IndexW-1:0]     burst_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ssbfs_pkg::SymW-1:0]       first_symbol,
  output logic [ssbfs_pkg::StatusW-1:0]    status
);

  ssbfs_pkg::cfg_t cfg;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        ssbfs_pkg::REG_PATTERN: cfg.pattern     <= pwdata[ssbfs_pkg::PatW-1:0];
        ssbfs_pkg::REG_CARRIER: cfg.carrier_khz <= pwdata[ssbfs_pkg::CarrierW-1:0];
        ssbfs_pkg::REG_DUPLEX:  cfg.duplex_tdd  <= pwdata[0];
        ssbfs_pkg::REG_MASK:    cfg.active_mask <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      ssbfs_pkg::REG_PATTERN: prdata = ssbfs_pkg::DataW'(cfg.pattern);
      ssbfs_pkg::REG_CARRIER: prdata = ssbfs_pkg::DataW'(cfg.carrier_khz);
      ssbfs_pkg::REG_DUPLEX:  prdata = ssbfs_pkg::DataW'(cfg.duplex_tdd);
      ssbfs_pkg::REG_MASK:    prdata = cfg.active_mask;
      default:                prdata = '0;
    endcase
  end

  // lookup pipeline
  ssbfs_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .burst_index  (burst_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_symbol (first_symbol),
    .status       (status)
  );

endmodule

>>> src/ssbfs_pipe.sv
`timescale 1ns / 1ps
// four-stage lookup pipeline: length mask, byte counts and prefixes,
// group select, bit select and symbol; depends on ssbfs_pkg
module ssbfs_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  ssbfs_pkg::cfg_t                cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ssbfs_pkg::IndexW-1:0]   burst_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ssbfs_pkg::SymW-1:0]     first_symbol,
  output logic [ssbfs_pkg::StatusW-1:0]  status
);

  // stage valids and ready chain, each stage loads when empty or moving on
  logic v1, v2, v3;
  logic ready1, ready2, ready3, ready4;

  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // stage 1: scan length mask
  logic [ssbfs_pkg::MaskW-1:0]  s1_mask;
  logic [ssbfs_pkg::IndexW-1:0] s1_want;
  logic [ssbfs_pkg::PatW-1:0]   s1_pat;
  logic                         s1_pat_ok;
  logic [ssbfs_pkg::LenW-1:0]   len;
  logic [ssbfs_pkg::MaskW-1:0]  len_mask;

  always_comb begin
    len = ssbfs_pkg::list_len(cfg.pattern, cfg.carrier_khz, cfg.duplex_tdd);
    for (int i = 0; i < ssbfs_pkg::MaskW; i++) begin
      len_mask[i] = ssbfs_pkg::LenW'(i) < len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
    if (ready1 && in_valid) begin
      s1_mask   <= cfg.active_mask & len_mask;
      s1_want   <= burst_index;
      s1_pat    <= cfg.pattern;
      s1_pat_ok <= cfg.pattern <= ssbfs_pkg::PAT_E;
    end
  end

  // stage 2: per-byte set-bit counts and running prefixes
  logic [ssbfs_pkg::GroupW-1:0] s2_byte [ssbfs_pkg::NGroups];
  logic [ssbfs_pkg::CntW-1:0]   s2_cnt  [ssbfs_pkg::NGroups];
  logic [ssbfs_pkg::PreW-1:0]   s2_pre  [ssbfs_pkg::NGroups];
  logic [ssbfs_pkg::IndexW-1:0] s2_want;
  logic [ssbfs_pkg::PatW-1:0]   s2_pat;
  logic                         s2_pat_ok;
  logic [ssbfs_pkg::CntW-1:0]   cnt    [ssbfs_pkg::NGroups];
  logic [ssbfs_pkg::PreW-1:0]   pre    [ssbfs_pkg::NGroups];

  always_comb begin
    for (int g = 0; g < ssbfs_pkg::NGroups; g++) begin
      cnt[g] = ssbfs_pkg::CntW'($countones(s1_mask[g*ssbfs_pkg::GroupW +:
                                                   ssbfs_pkg::GroupW]));
    end
    pre[0] = '0;
    for (int g = 1; g < ssbfs_pkg::NGroups; g++) begin
      pre[g] = pre[g-1] + ssbfs_pkg::PreW'(cnt[g-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2 && v1) begin
      for (int g = 0; g < ssbfs_pkg::NGroups; g++) begin
        s2_byte[g] <= s1_mask[g*ssbfs_pkg::GroupW +: ssbfs_pkg::GroupW];
        s2_cnt[g]  <= cnt[g];
        s2_pre[g]  <= pre[g];
      end
      s2_want   <= s1_want;
      s2_pat    <= s1_pat;
      s2_pat_ok <= s1_pat_ok;
    end
  end

  // stage 3: pick the byte that holds the wanted set bit
  logic [ssbfs_pkg::GroupW-1:0]  s3_byte;
  logic [ssbfs_pkg::GrpIdxW-1:0] s3_grp;
  logic [ssbfs_pkg::BitIdxW-1:0] s3_rank;
  logic                          s3_found;
  logic [ssbfs_pkg::PatW-1:0]    s3_pat;
  logic                          s3_pat_ok;
  logic [ssbfs_pkg::GroupW-1:0]  sel_byte;
  logic [ssbfs_pkg::GrpIdxW-1:0] sel_grp;
  logic [ssbfs_pkg::BitIdxW-1:0] sel_rank;
  logic                          sel_found;
  logic [ssbfs_pkg::PreW-1:0]    want_w;
  logic [ssbfs_pkg::PreW-1:0]    diff;

  always_comb begin
    sel_byte  = '0;
    sel_grp   = '0;
    sel_rank  = '0;
    sel_found = 1'b0;
    diff      = '0;
    want_w    = ssbfs_pkg::PreW'(s2_want);
    for (int g = 0; g < ssbfs_pkg::NGroups; g++) begin
      if ((want_w >= s2_pre[g]) &&
          (want_w < s2_pre[g] + ssbfs_pkg::PreW'(s2_cnt[g]))) begin
        diff      = want_w - s2_pre[g];
        sel_byte  = s2_byte[g];
        sel_grp   = ssbfs_pkg::GrpIdxW'(g);
        sel_rank  = diff[ssbfs_pkg::BitIdxW-1:0];
        sel_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (ready3 && v2) begin
      s3_byte   <= sel_byte;
      s3_grp    <= sel_grp;
      s3_rank   <= sel_rank;
      s3_found  <= sel_found;
      s3_pat    <= s2_pat;
      s3_pat_ok <= s2_pat_ok;
    end
  end

  // stage 4: bit within the byte, candidate symbol, status
  logic [ssbfs_pkg::CntW-1:0]    run;
  logic [ssbfs_pkg::BitIdxW-1:0] bit_idx;
  logic                          bit_hit;
  logic [ssbfs_pkg::IndexW-1:0]  pos;
  logic [ssbfs_pkg::SymW-1:0]    sym_next;
  logic [ssbfs_pkg::StatusW-1:0] status_next;

  always_comb begin
    run     = '0;
    bit_idx = '0;
    bit_hit = 1'b0;
    for (int b = 0; b < ssbfs_pkg::GroupW; b++) begin
      if (s3_byte[b] && !bit_hit && (run == ssbfs_pkg::CntW'(s3_rank))) begin
        bit_idx = ssbfs_pkg::BitIdxW'(b);
        bit_hit = 1'b1;
      end
      run = run + ssbfs_pkg::CntW'(s3_byte[b]);
    end
    pos = {s3_grp, bit_idx};
    if (!s3_pat_ok) begin
      sym_next    = '0;
      status_next = ssbfs_pkg::STATUS_BAD_PATTERN;
    end else if (!s3_found) begin
      sym_next    = '0;
      status_next = ssbfs_pkg::STATUS_MISSING;
    end else begin
      sym_next    = ssbfs_pkg::cand_symbol(s3_pat, pos);
      status_next = ssbfs_pkg::STATUS_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= v3;
    end
    if (ready4 && v3) begin
      first_symbol <= sym_next;
      status       <= status_next;
    end
  end

endmodule

>>> src/ssbfs_checker.sv
`timescale 1ns / 1ps
// port-level checks on the first symbol lookup and the bind that attaches
// them to ssb_burst_first_symbol_top; depends on ssbfs_pkg
module ssbfs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ssbfs_pkg::SymW-1:0]      first_symbol,
  input logic [ssbfs_pkg::StatusW-1:0]   status
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // an empty pipeline takes an item right after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // no symbol is reported with a failing status
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ssbfs_pkg::STATUS_FOUND) |-> first_symbol == '0)
    else $error("nonzero symbol with failing status");

  // every candidate first symbol is even and within the slot range
  a_sym_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ssbfs_pkg::STATUS_FOUND) |->
      (first_symbol <= 10'd524) && !first_symbol[0])
    else $error("found symbol outside candidate range");

endmodule

bind ssb_burst_first_symbol_top ssbfs_checker u_ssbfs_checker (.*);

>>> tb/sv/tb_ssb_burst_first_symbol_top.sv
`timescale 1ns / 1ps
// self-checking bench for the sync block first-symbol lookup: directed table,
// then random configuration phases, checked against a local symbol predictor
// depends on ssbfs_pkg and ssb_burst_first_symbol_top
module tb_ssb_burst_first_symbol_top;
  import ssbfs_pkg::*;

  // patterns outside A to E
  localparam logic [PatW-1:0] PAT_BAD_LO = 3'd5;
  localparam logic [PatW-1:0] PAT_BAD_HI = 3'd7;

  localparam logic [CarrierW-1:0] KHZ_3G     = 27'd3000000;
  localparam logic [CarrierW-1:0] KHZ_2G3    = 27'd2300000;
  localparam logic [CarrierW-1:0] KHZ_TOP    = 27'h7FFFFFF;
  localparam logic [MaskW-1:0]    MASK_FULL  = {MaskW{1'b1}};
  localparam int                  PHASES     = 20;
  localparam int                  PHASE_ITEMS = 30;
  localparam int                  DRAIN_CYCLES = 8;

  // candidate tables, local copy
  localparam int unsigned SYM_PAIR [2]  = '{2, 8};
  localparam int unsigned SYM_QUAD [4]  = '{4, 8, 16, 20};
  localparam int unsigned SYM_OCT [8]   = '{8, 12, 16, 20, 32, 36, 40, 44};
  localparam int unsigned SLOT_D [16]   = '{0, 1, 2, 3, 5, 6, 7, 8,
                                           10, 11, 12, 13, 15, 16, 17, 18};
  localparam int unsigned SLOT_E [8]    = '{0, 1, 2, 3, 5, 6, 7, 8};

  typedef struct packed {
    logic [SymW-1:0]    first_symbol;
    logic [StatusW-1:0] status;
  } sym_result_t;

  typedef struct packed {
    bit                 is_write;
    logic [1:0]         reg_sel;
    logic [MaskW-1:0]   value;
    logic [IndexW-1:0]  index;
    bit                 typed;
    sym_result_t        want;
  } step_row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic [IndexW-1:0]   burst_index;
  logic                out_valid;
  logic                out_stall;
  logic [SymW-1:0]     first_symbol;
  logic [StatusW-1:0]  status;

  // configuration shadow
  logic [PatW-1:0]     sh_pattern;
  logic [CarrierW-1:0] sh_carrier;
  logic                sh_tdd;
  logic [MaskW-1:0]    sh_mask;

  sym_result_t pending_symbols[$];
  step_row_t   directed_rows[$];
  int          mismatches;
  int          items_sent;
  int          results_seen;
  int          reg_writes;
  int          gap_odds;
  int          stall_left;

  ssb_burst_first_symbol_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .burst_index  (burst_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_symbol (first_symbol),
    .status       (status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("ssb_burst_first_symbol_top regression: fail");
    $finish;
  end

  // number of candidate positions scanned under the shadow configuration
  function automatic int unsigned scan_length();
    bit above3;
    int unsigned len;
    above3 = sh_carrier > KHZ_3G;
    case (sh_pattern)
      PAT_A, PAT_B: len = above3 ? 8 : 4;
      PAT_C: begin
        if (sh_tdd) len = (sh_carrier <= KHZ_2G3) ? 4 : 8;
        else len = above3 ? 8 : 4;
      end
      PAT_D, PAT_E: len = 64;
      default: len = 0;
    endcase
    if (len > MaxPositions) len = MaxPositions;
    return len;
  endfunction

  // set bits of the mask inside the scanned positions
  function automatic int unsigned scanned_ones();
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < scan_length(); i++) n += sh_mask[i];
    return n;
  endfunction

  // first symbol of the burst_index-th transmitted candidate
  function automatic sym_result_t predict_symbol(logic [IndexW-1:0] idx);
    sym_result_t r;
    int unsigned seen;
    int unsigned sym;
    r.first_symbol = '0;
    r.status = STATUS_MISSING;
    seen = 0;
    if (sh_pattern > PAT_E) begin
      r.status = STATUS_BAD_PATTERN;
      return r;
    end
    for (int unsigned pos = 0; pos < scan_length(); pos++) begin
      if (sh_mask[pos]) begin
        if (seen == idx) begin
          case (sh_pattern)
            PAT_A, PAT_C: sym = SYM_PAIR[pos % 2] + 14 * (pos / 2);
            PAT_B:        sym = SYM_QUAD[pos % 4] + 28 * (pos / 4);
            PAT_D:        sym = SYM_QUAD[pos % 4] + 28 * SLOT_D[(pos / 4) % 16];
            default:      sym = SYM_OCT[pos % 8] + 56 * SLOT_E[(pos / 8) % 8];
          endcase
          r.first_symbol = sym[SymW-1:0];
          r.status = STATUS_FOUND;
          return r;
        end
        seen++;
      end
    end
    return r;
  endfunction

  // table row builders
  function automatic step_row_t wr(logic [1:0] reg_sel, logic [MaskW-1:0] value);
    step_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_sel = reg_sel;
    row.value = value;
    return row;
  endfunction

  function automatic step_row_t ask(logic [IndexW-1:0] idx);
    step_row_t row;
    row = '0;
    row.index = idx;
    return row;
  endfunction

  function automatic step_row_t ask_exp(logic [IndexW-1:0] idx, logic [SymW-1:0] sym,
                                        logic [StatusW-1:0] st);
    step_row_t row;
    row = ask(idx);
    row.typed = 1'b1;
    row.want.first_symbol = sym;
    row.want.status = st;
    return row;
  endfunction

  // register write: setup then access phase
  task automatic apb_write(input logic [1:0] reg_sel, input logic [MaskW-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_sel)
      REG_PATTERN: sh_pattern = value[PatW-1:0];
      REG_CARRIER: sh_carrier = value[CarrierW-1:0];
      REG_DUPLEX:  sh_tdd = value[0];
      default:     sh_mask = value;
    endcase
    reg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // let every pending result come out before touching the registers
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offer one item, with an optional idle burst in front
  task automatic send_index(input logic [IndexW-1:0] idx, input bit typed,
                            input sym_result_t want);
    @(negedge clk);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    burst_index = idx;
    do @(posedge clk); while (in_stall);
    pending_symbols.push_back(typed ? want : predict_symbol(idx));
    items_sent++;
  endtask

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        stall_left = $urandom_range(1, 15);
      out_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // result checker
  initial begin
    sym_result_t exp_r;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (pending_symbols.size() == 0) begin
          $error("result with nothing pending: first_symbol %0d status %0d",
                 first_symbol, status);
          mismatches++;
        end else begin
          exp_r = pending_symbols.pop_front();
          if (first_symbol !== exp_r.first_symbol) begin
            $error("first_symbol expected %0d actual %0d", exp_r.first_symbol,
                   first_symbol);
            mismatches++;
          end
          if (status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, status);
            mismatches++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [MaskW-1:0] rmask;
    logic [IndexW-1:0] idx;
    int unsigned ones;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    burst_index = '0;
    sh_pattern = '0;
    sh_carrier = '0;
    sh_tdd = 1'b0;
    sh_mask = '0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    gap_odds = 4;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: reset state, thresholds, list ends, ignored mask bits,
    // bad patterns, out-of-range carrier
    directed_rows.push_back(ask_exp(6'd0, 10'd0, STATUS_MISSING));
    directed_rows.push_back(ask_exp(6'd63, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_MASK, MASK_FULL));
    directed_rows.push_back(ask_exp(6'd0, 10'd2, STATUS_FOUND));
    directed_rows.push_back(ask_exp(6'd3, 10'd22, STATUS_FOUND));
    directed_rows.push_back(ask_exp(6'd4, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_CARRIER, 64'(KHZ_3G)));
    directed_rows.push_back(ask_exp(6'd4, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_CARRIER, 64'(KHZ_3G) + 64'd1));
    directed_rows.push_back(ask_exp(6'd7, 10'd50, STATUS_FOUND));
    directed_rows.push_back(ask_exp(6'd8, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_PATTERN, 64'(PAT_B)));
    directed_rows.push_back(ask_exp(6'd7, 10'd48, STATUS_FOUND));
    directed_rows.push_back(ask(6'd2));
    directed_rows.push_back(wr(REG_PATTERN, 64'(PAT_C)));
    directed_rows.push_back(wr(REG_DUPLEX, 64'd1));
    directed_rows.push_back(wr(REG_CARRIER, 64'(KHZ_2G3)));
    directed_rows.push_back(ask_exp(6'd4, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_CARRIER, 64'(KHZ_2G3) + 64'd1));
    directed_rows.push_back(ask_exp(6'd4, 10'd30, STATUS_FOUND));
    directed_rows.push_back(wr(REG_CARRIER, 64'(KHZ_TOP)));
    directed_rows.push_back(ask(6'd7));
    directed_rows.push_back(wr(REG_DUPLEX, 64'd0));
    directed_rows.push_back(wr(REG_CARRIER, 64'(KHZ_2G3) + 64'd1));
    directed_rows.push_back(ask_exp(6'd4, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_PATTERN, 64'(PAT_D)));
    directed_rows.push_back(ask_exp(6'd63, 10'd524, STATUS_FOUND));
    directed_rows.push_back(ask_exp(6'd0, 10'd4, STATUS_FOUND));
    directed_rows.push_back(ask(6'd37));
    directed_rows.push_back(wr(REG_PATTERN, 64'(PAT_E)));
    directed_rows.push_back(ask_exp(6'd63, 10'd492, STATUS_FOUND));
    // the corrected base value of pattern E
    directed_rows.push_back(ask_exp(6'd5, 10'd36, STATUS_FOUND));
    directed_rows.push_back(wr(REG_MASK, 64'h8000_0000_0000_0001));
    directed_rows.push_back(ask_exp(6'd1, 10'd492, STATUS_FOUND));
    directed_rows.push_back(ask_exp(6'd2, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_PATTERN, 64'(PAT_A)));
    directed_rows.push_back(wr(REG_CARRIER, 64'd0));
    directed_rows.push_back(wr(REG_MASK, 64'hFFFF_FFFF_FFFF_FFF0));
    directed_rows.push_back(ask_exp(6'd0, 10'd0, STATUS_MISSING));
    directed_rows.push_back(wr(REG_PATTERN, 64'(PAT_BAD_LO)));
    directed_rows.push_back(ask_exp(6'd0, 10'd0, STATUS_BAD_PATTERN));
    directed_rows.push_back(wr(REG_PATTERN, 64'(PAT_BAD_HI)));
    directed_rows.push_back(ask_exp(6'd63, 10'd0, STATUS_BAD_PATTERN));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain();
        apb_write(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_index(directed_rows[i].index, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each with a fresh configuration; the tail runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0:       gap_odds = 0;
        1:       gap_odds = 2;
        2:       gap_odds = 4;
        default: gap_odds = 8;
      endcase
      if (ph >= PHASES - 3) gap_odds = 0;
      if ($urandom_range(0, 9) == 0) apb_write(REG_PATTERN, 64'($urandom_range(5, 7)));
      else apb_write(REG_PATTERN, 64'($urandom_range(0, 4)));
      case ($urandom_range(0, 7))
        0:       apb_write(REG_CARRIER, 64'd0);
        1:       apb_write(REG_CARRIER, 64'(KHZ_3G));
        2:       apb_write(REG_CARRIER, 64'(KHZ_3G) + 64'd1);
        3:       apb_write(REG_CARRIER, 64'(KHZ_2G3));
        4:       apb_write(REG_CARRIER, 64'(KHZ_2G3) + 64'd1);
        5:       apb_write(REG_CARRIER, 64'(KHZ_TOP));
        default: apb_write(REG_CARRIER, 64'($urandom_range(0, 100000000)));
      endcase
      apb_write(REG_DUPLEX, 64'($urandom_range(0, 1)));
      case ($urandom_range(0, 4))
        0: rmask = MASK_FULL;
        1: rmask = {$urandom, $urandom};
        2: rmask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        3: rmask = {$urandom, $urandom} | {$urandom, $urandom};
        default: begin
          rmask = '0;
          if ($urandom_range(0, 3) != 0) rmask[$urandom_range(0, 63)] = 1'b1;
        end
      endcase
      apb_write(REG_MASK, rmask);
      ones = scanned_ones();
      // mostly indexes from the first transmitted block to just past the last one
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ones == 0 || $urandom_range(0, 7) == 0) idx = IndexW'($urandom_range(0, 63));
        else idx = IndexW'($urandom_range(0, (ones > 63) ? 63 : ones));
        send_index(idx, 1'b0, '0);
      end
    end

    // wind down
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d results over %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("patterns A to E plus bad codes, both carrier thresholds, FDD and TDD");
    if (mismatches == 0) begin
      $display("ssb_burst_first_symbol_top regression: pass");
    end else begin
      $display("ssb_burst_first_symbol_top regression: fail");
    end
    $finish;
  end

endmodule

>>> ssb_burst_first_symbol_top.f
src/ssbfs_pkg.sv
src/ssbfs_pipe.sv
src/ssb_burst_first_symbol_top.sv
src/ssbfs_checker.sv
tb/sv/tb_ssb_burst_first_symbol_top.sv
